// File: hw/rtl/cusum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CUSUM package
// Register map, reset values and the configuration bundle shared by the
// register file and the update logic.
// ----------------------------------------------------------------------------
package cusum_pkg;

    localparam int THR_W   = 24;
    localparam int DRIFT_W = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [THR_W-1:0]   THR_RESET   = 24'd10;
    localparam logic [DRIFT_W-1:0] DRIFT_RESET = 16'd1;

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_DRIFT     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [DRIFT_W-1:0] drift;
    } t_cfg;

endpackage

// File: hw/rtl/cusum_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CUSUM configuration registers
// APB-style register file holding the alarm threshold and drift allowance.
// ----------------------------------------------------------------------------
module cusum_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cusum_pkg::ADDR_W-1:0]  paddr,
    input  logic [cusum_pkg::DATA_W-1:0]  pwdata,
    output logic [cusum_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output cusum_pkg::t_cfg               o_cfg
);

    cusum_pkg::t_cfg   r_cfg;
    cusum_pkg::t_cfg   n_cfg;
    cusum_pkg::t_reg_idx s_idx;
    logic              s_wr;

    // Word address: bit 2 selects the register, low bits are ignored.
    assign s_idx = cusum_pkg::t_reg_idx'(paddr[2]);
    assign s_wr  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (s_wr) begin
            unique case (s_idx)
                cusum_pkg::REG_THRESHOLD: n_cfg.threshold = pwdata[cusum_pkg::THR_W-1:0];
                cusum_pkg::REG_DRIFT:     n_cfg.drift     = pwdata[cusum_pkg::DRIFT_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= cusum_pkg::THR_RESET;
            r_cfg.drift     <= cusum_pkg::DRIFT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (s_idx)
            cusum_pkg::REG_THRESHOLD: prdata = {{(cusum_pkg::DATA_W-cusum_pkg::THR_W){1'b0}},
                                                r_cfg.threshold};
            cusum_pkg::REG_DRIFT:     prdata = {{(cusum_pkg::DATA_W-cusum_pkg::DRIFT_W){1'b0}},
                                                r_cfg.drift};
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// File: hw/rtl/cusum_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CUSUM update
// Series state and the two-sided sum update, clamp and alarm test.
// ----------------------------------------------------------------------------
module cusum_update #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int INDEX_WIDTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cusum_pkg::t_cfg         i_cfg,
    input  logic                    i_step,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_last,
    output logic                    o_alarm,
    output logic [INDEX_WIDTH-1:0]  o_index,
    output logic [INDEX_WIDTH-1:0]  o_number
);

    localparam int THR_W  = cusum_pkg::THR_W;
    localparam int WIDE_W = (SAMPLE_WIDTH + 1 > THR_W) ? SAMPLE_WIDTH + 1 : THR_W;
    localparam int CALC_W = WIDE_W + 2;

    logic [SAMPLE_WIDTH-1:0] r_prev;
    logic                    r_have;
    logic [THR_W-1:0]        r_up;
    logic [THR_W-1:0]        r_down;
    logic [INDEX_WIDTH-1:0]  r_pos;
    logic [INDEX_WIDTH-1:0]  r_count;

    logic [THR_W-1:0]        n_up;
    logic [THR_W-1:0]        n_down;
    logic [INDEX_WIDTH-1:0]  n_pos;
    logic [INDEX_WIDTH-1:0]  n_count;

    logic signed [CALC_W-1:0] s_diff;
    logic signed [CALC_W-1:0] s_drift;
    logic signed [CALC_W-1:0] s_thr;
    logic signed [CALC_W-1:0] s_up_raw;
    logic signed [CALC_W-1:0] s_down_raw;
    logic signed [CALC_W-1:0] s_up;
    logic signed [CALC_W-1:0] s_down;

    assign s_diff = $signed({{(CALC_W-SAMPLE_WIDTH){i_sample[SAMPLE_WIDTH-1]}}, i_sample})
                  - $signed({{(CALC_W-SAMPLE_WIDTH){r_prev[SAMPLE_WIDTH-1]}}, r_prev});
    assign s_drift = $signed({{(CALC_W-cusum_pkg::DRIFT_W){1'b0}}, i_cfg.drift});
    assign s_thr   = $signed({{(CALC_W-THR_W){1'b0}}, i_cfg.threshold});

    assign s_up_raw   = $signed({{(CALC_W-THR_W){1'b0}}, r_up}) + s_diff - s_drift;
    assign s_down_raw = $signed({{(CALC_W-THR_W){1'b0}}, r_down}) - s_diff - s_drift;

    // Clamp negative sums at zero.
    assign s_up   = s_up_raw[CALC_W-1]   ? '0 : s_up_raw;
    assign s_down = s_down_raw[CALC_W-1] ? '0 : s_down_raw;

    assign o_alarm = r_have && ((s_up > s_thr) || (s_down > s_thr));

    assign n_pos   = (&r_pos)   ? r_pos   : r_pos + 1'b1;
    assign n_count = (&r_count) ? r_count : r_count + 1'b1;

    // Without an alarm both sums are at most the threshold, so they fit.
    always_comb begin
        n_up   = r_up;
        n_down = r_down;
        if (r_have) begin
            n_up   = o_alarm ? '0 : s_up[THR_W-1:0];
            n_down = o_alarm ? '0 : s_down[THR_W-1:0];
        end
    end

    assign o_index  = r_pos;
    assign o_number = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_up    <= '0;
            r_down  <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_prev  <= '0;
                r_have  <= 1'b0;
                r_up    <= '0;
                r_down  <= '0;
                r_pos   <= '0;
                r_count <= '0;
            end else begin
                r_prev  <= i_sample;
                r_have  <= 1'b1;
                r_up    <= n_up;
                r_down  <= n_down;
                r_pos   <= n_pos;
                r_count <= o_alarm ? n_count : r_count;
            end
        end
    end

endmodule

// File: hw/rtl/cusum_change_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CUSUM change detector
// Two-sided cumulative-sum anomaly detector over a series of signed samples.
// ----------------------------------------------------------------------------
// Registers: input register, then result register, with the sum update
//   between the two.
// Throughput: one item per cycle while the result register is not stalled;
//   the state update is one add, subtract, clamp and compare pass.
// Reset: synchronous, active low; clears series state and the handshake
//   flags, loads threshold 10 and drift 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module cusum_change_detector #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int INDEX_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]       i_sample_value,
    input  logic                          i_last_sample,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [INDEX_WIDTH-1:0]        o_anomaly_index,
    output logic [INDEX_WIDTH-1:0]        o_anomaly_number,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cusum_pkg::ADDR_W-1:0]  paddr,
    input  logic [cusum_pkg::DATA_W-1:0]  pwdata,
    output logic [cusum_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    cusum_pkg::t_cfg s_cfg;

    // Input register
    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                    r_in_last;

    // Result register
    logic                    r_out_valid;
    logic [INDEX_WIDTH-1:0]  r_out_index;
    logic [INDEX_WIDTH-1:0]  r_out_number;

    logic                    s_advance;
    logic                    s_alarm;
    logic [INDEX_WIDTH-1:0]  s_index;
    logic [INDEX_WIDTH-1:0]  s_number;

    cusum_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // Advance the held item into the state whenever the result register can
    // take whatever it produces: either empty or being drained this cycle.
    assign s_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_advance;

    cusum_update #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .INDEX_WIDTH  (INDEX_WIDTH)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (s_cfg),
        .i_step   (s_advance),
        .i_sample (r_in_sample),
        .i_last   (r_in_last),
        .o_alarm  (s_alarm),
        .o_index  (s_index),
        .o_number (s_number)
    );

    // Capture a new item whenever the input register frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_sample <= i_sample_value;
            r_in_last   <= i_last_sample;
        end
    end

    // Load a result on alarm; drop it once the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance && s_alarm) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_alarm) begin
            r_out_index  <= s_index;
            r_out_number <= s_number;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_anomaly_index  = r_out_index;
    assign o_anomaly_number = r_out_number;

`ifndef SYNTHESIS
    // A stalled result must block the held item from advancing.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result register stalled and full");

    // An alarm taken into the state always lands in the result register.
    a_alarm_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_advance && s_alarm) |=> r_out_valid)
        else $error("alarm lost between update and result register");

    // The first sample never alarms, and the count cannot pass the position.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_number != '0 && r_out_number <= r_out_index))
        else $error("anomaly number out of range for its index");
`endif

endmodule
